### hdl/lcst_pkg.sv
// ----------------------------------------------------------------------------
// lcst_pkg
// shared types and constants for the line call state table
// ----------------------------------------------------------------------------
package lcst_pkg;

    // number of lines; the line index doubles as the extension
    localparam int LINES  = 16;
    localparam int LINE_W = $clog2(LINES);

    // command codes
    typedef enum logic [1:0] {
        OP_PICKUP = 2'd0,
        OP_HANGUP = 2'd1,
        OP_DIAL   = 2'd2,
        OP_CHAT   = 2'd3
    } t_opcode;

    // per-line call state as seen by the client
    typedef enum logic [2:0] {
        ST_ON_HOOK   = 3'd0,
        ST_RINGING   = 3'd1,
        ST_DIAL_TONE = 3'd2,
        ST_RING_BACK = 3'd3,
        ST_BUSY      = 3'd4,
        ST_CONNECTED = 3'd5,
        ST_ERROR     = 3'd6
    } t_call_state;

    // one table entry; all zero is the reset value (on-hook, no peer)
    typedef struct packed {
        t_call_state             state;
        logic [LINE_W-1:0]       peer;
        logic                    peer_vld;
    } t_entry;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LREAD = 8'b0000_0010,
        S_PREAD = 8'b0000_0100,
        S_WPEER = 8'b0000_1000,
        S_WLINE = 8'b0001_0000,
        S_NRD   = 8'b0010_0000,
        S_NLOAD = 8'b0100_0000,
        S_NSEND = 8'b1000_0000
    } t_fsm;

endpackage

### hdl/line_call_state_table_core.sv
// a command is read, decided, written back and then notified: the sequencer steps through
//   S_LREAD, S_PREAD, S_WPEER, S_WLINE, S_NRD and S_NLOAD before the first notification
//   is valid; a new command is taken only once the sequencer is back in S_IDLE after the
//   last of its one or two notifications, so any output stall also holds up commands
// reset: synchronous active-low; all lines read as on-hook with no peer at once,
//   through per-entry valid flags, so no clearing pass is needed
// ----------------------------------------------------------------------------
// line_call_state_table_core
// call state and peer link per telephone line, updated by pickup, hangup,
// dial and chat-check commands, with a notification stream per command
// ----------------------------------------------------------------------------
module line_call_state_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [3:0] line, [7:4] target_line, [8] target_known
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    // notification stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [3:0] note_line, [6:4] note_state, [10:7] note_peer
    output logic        o_m_tuser,   // [0] status
    output logic        o_m_tlast    // final notification of the command
);
    import lcst_pkg::*;

    // ------------------------------------------------------------------
    // entry table: one write port, one registered read port
    // r_vld marks entries written since reset; others read as reset value
    // ------------------------------------------------------------------
    t_entry            r_mem [LINES];
    logic [LINES-1:0]  r_vld;
    t_entry            r_rd_ent;
    logic              r_rd_vld;
    t_entry            rd_ent;       // effective read data
    logic [LINE_W-1:0] rd_addr;
    logic              wr_en;
    logic [LINE_W-1:0] wr_addr;
    t_entry            wr_data;

    assign rd_ent = r_rd_vld ? r_rd_ent : t_entry'('0);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_ent <= r_mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // command registers
    // ------------------------------------------------------------------
    t_fsm              r_state, n_state;
    t_opcode           r_op;
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] r_tg;
    logic              r_known;      // target resolved and within the table
    t_entry            r_ln_ent;     // issuing line's entry before the command

    // decisions taken once both entries are in hand
    t_entry            r_new_ln, n_new_ln;
    t_entry            r_new_pr, n_new_pr;
    logic [LINE_W-1:0] r_pr_addr, n_pr_addr;
    logic              r_pr_upd, n_pr_upd;     // peer written and notified
    logic              r_status, n_status;
    logic              r_note_is_peer;         // notification under way is the peer's

    // output register
    logic              r_out_vld;
    logic [3:0]        r_out_line;
    t_call_state       r_out_state;
    logic [3:0]        r_out_peer;
    logic              r_out_status;
    logic              r_out_last;

    logic              in_xfer;
    logic              line_ok;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    // a line index beyond the table is dropped without notification
    assign line_ok    = int'(i_s_tdata[3:0]) < LINES;

    // ------------------------------------------------------------------
    // table port addressing
    // ------------------------------------------------------------------
    always_comb begin
        rd_addr = r_line;
        case (r_state)
            S_IDLE:  rd_addr = i_s_tdata[LINE_W-1:0];
            // second read: dial target, or the linked peer otherwise
            S_LREAD: rd_addr = (r_op == OP_DIAL) ? r_tg : rd_ent.peer;
            S_NRD:   rd_addr = r_note_is_peer ? r_pr_addr : r_line;
            default: rd_addr = r_line;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_line;
        wr_data = r_new_ln;
        case (r_state)
            S_WPEER: begin
                wr_en   = r_pr_upd;
                wr_addr = r_pr_addr;
                wr_data = r_new_pr;
            end
            S_WLINE: begin
                wr_en   = 1'b1;
                wr_addr = r_line;
                wr_data = r_new_ln;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // command decode: r_ln_ent is the issuing line, rd_ent the second entry
    // ------------------------------------------------------------------
    always_comb begin
        n_new_ln  = r_ln_ent;
        n_new_pr  = rd_ent;
        n_pr_addr = r_ln_ent.peer;
        n_pr_upd  = 1'b0;
        n_status  = 1'b0;
        case (r_op)
            OP_PICKUP: begin
                if (r_ln_ent.state == ST_ON_HOOK) begin
                    n_new_ln.state = ST_DIAL_TONE;
                end else if (r_ln_ent.state == ST_RINGING && r_ln_ent.peer_vld) begin
                    // answer: both ends connected, the peer keeps its own link
                    n_new_ln.state = ST_CONNECTED;
                    n_new_pr.state = ST_CONNECTED;
                    n_pr_upd       = 1'b1;
                end
            end
            OP_HANGUP: begin
                if (r_ln_ent.peer_vld && (r_ln_ent.state == ST_CONNECTED ||
                                          r_ln_ent.state == ST_RINGING ||
                                          r_ln_ent.state == ST_RING_BACK)) begin
                    n_new_pr.state    = (r_ln_ent.state == ST_RING_BACK) ?
                                        ST_ON_HOOK : ST_DIAL_TONE;
                    n_new_pr.peer     = '0;
                    n_new_pr.peer_vld = 1'b0;
                    n_pr_upd          = 1'b1;
                end
                n_new_ln = t_entry'('0);
            end
            OP_DIAL: begin
                n_pr_addr = r_tg;
                if (r_ln_ent.state == ST_DIAL_TONE) begin
                    if (!r_known) begin
                        n_new_ln.state = ST_ERROR;
                    end else if (r_tg == r_line || rd_ent.peer_vld ||
                                 rd_ent.state != ST_ON_HOOK) begin
                        n_new_ln.state = ST_BUSY;
                    end else begin
                        n_new_ln.state    = ST_RING_BACK;
                        n_new_ln.peer     = r_tg;
                        n_new_ln.peer_vld = 1'b1;
                        n_new_pr.state    = ST_RINGING;
                        n_new_pr.peer     = r_line;
                        n_new_pr.peer_vld = 1'b1;
                        n_pr_upd          = 1'b1;
                    end
                end
            end
            OP_CHAT: begin
                n_status = (r_ln_ent.state != ST_CONNECTED);
            end
            default: n_pr_upd = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer && line_ok) n_state = S_LREAD;
            S_LREAD: n_state = S_PREAD;
            S_PREAD: n_state = S_WPEER;
            S_WPEER: n_state = S_WLINE;
            S_WLINE: n_state = S_NRD;
            S_NRD:   n_state = S_NLOAD;
            S_NLOAD: n_state = S_NSEND;
            S_NSEND: begin
                if (i_m_tready) begin
                    n_state = r_note_is_peer ? S_NRD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_vld      <= 1'b0;
            r_note_is_peer <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_WLINE: r_note_is_peer <= r_pr_upd;
                S_NLOAD: r_out_vld <= 1'b1;
                S_NSEND: begin
                    if (i_m_tready) begin
                        r_out_vld      <= 1'b0;
                        r_note_is_peer <= 1'b0;
                    end
                end
                default: r_out_vld <= r_out_vld;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= t_opcode'(i_s_tuser);
            r_line  <= i_s_tdata[LINE_W-1:0];
            r_tg    <= i_s_tdata[4 +: LINE_W];
            r_known <= i_s_tdata[8] && (int'(i_s_tdata[7:4]) < LINES);
        end
        if (r_state == S_LREAD) begin
            r_ln_ent <= rd_ent;
        end
        if (r_state == S_PREAD) begin
            r_new_ln  <= n_new_ln;
            r_new_pr  <= n_new_pr;
            r_pr_addr <= n_pr_addr;
            r_pr_upd  <= n_pr_upd;
            r_status  <= n_status;
        end
        if (r_state == S_NLOAD) begin
            // notification carries the entry as it stands after the update
            r_out_line   <= 4'(r_note_is_peer ? r_pr_addr : r_line);
            r_out_state  <= rd_ent.state;
            r_out_peer   <= (rd_ent.state == ST_CONNECTED && rd_ent.peer_vld) ?
                            4'(rd_ent.peer) : 4'd0;
            r_out_status <= r_note_is_peer ? 1'b0 : r_status;
            r_out_last   <= !r_note_is_peer;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_peer, r_out_state, r_out_line};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_onehot_fsm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_out_only_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_state == S_NSEND))
        else $error("output valid outside the send state");

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_out_vld)
        else $error("command taken while a notification is pending");

    a_last_matches_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (o_m_tlast == !r_note_is_peer))
        else $error("tlast disagrees with notification order");

    a_peer_then_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NSEND && i_m_tready && r_note_is_peer) |=>
            (r_state == S_NRD && !r_note_is_peer))
        else $error("line notification does not follow peer notification");
`endif

endmodule

### sim/tb_line_call_state_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_call_state_table_core
// self-checking bench for the line call state table: a short table of
// directed commands, then random call sequences, every notification checked
// against a bench-side copy of the line table, under random stalls
// ----------------------------------------------------------------------------
module tb_line_call_state_table_core;
    import lcst_pkg::*;

    localparam int RANDOM_CMDS = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 200;

    // one notification as seen on the output stream
    typedef struct packed {
        logic [LINE_W-1:0] line;
        t_call_state       state;
        logic [LINE_W-1:0] peer;
        logic              status;
        logic              last;
    } t_note;

    // one row of the directed table; typed rows carry the line's own notification
    typedef struct {
        t_opcode           op;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] target;
        logic              known;
        logic              typed;
        t_call_state       state;
        logic              status;
    } t_cmd_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [15:0]       i_s_tdata;   // [3:0] line, [7:4] target_line, [8] target_known
    logic [1:0]        i_s_tuser;   // [1:0] opcode
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [15:0]       o_m_tdata;   // [3:0] note_line, [6:4] note_state, [10:7] note_peer
    logic              o_m_tuser;   // [0] status
    logic              o_m_tlast;

    // bench copy of the line table
    t_call_state       line_state  [LINES];
    logic [LINE_W-1:0] line_peer   [LINES];
    logic              line_linked [LINES];

    t_note             pending_notes [$];
    t_cmd_row          cmd_table     [$];

    // typed notification that travels alongside the command being offered
    logic              drv_typed_vld;
    t_note             drv_typed;

    int                fail_count;
    int                hold_req;
    int                hold_ack;

    line_call_state_table_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_line_call_state_table_core: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // line table prediction
    // ------------------------------------------------------------------------

    // notification for a line, carrying the line's current state
    task automatic push_note(input logic [LINE_W-1:0] ln, input logic status,
                             input logic last);
        t_note n;
        n.line   = ln;
        n.state  = line_state[ln];
        n.peer   = (line_state[ln] == ST_CONNECTED && line_linked[ln]) ? line_peer[ln] : '0;
        n.status = status;
        n.last   = last;
        pending_notes.push_back(n);
    endtask

    task automatic apply_command(input t_opcode op, input logic [LINE_W-1:0] ln,
                                 input logic [LINE_W-1:0] tg, input logic known);
        t_call_state       st;
        logic [LINE_W-1:0] pr;
        logic              linked;
        st     = line_state[ln];
        pr     = line_peer[ln];
        linked = line_linked[ln];
        case (op)
            OP_PICKUP: begin
                if (st == ST_ON_HOOK) begin
                    line_state[ln] = ST_DIAL_TONE;
                end else if (st == ST_RINGING && linked) begin
                    // answering: both ends connect, caller told first
                    line_state[ln] = ST_CONNECTED;
                    line_state[pr] = ST_CONNECTED;
                    push_note(pr, 1'b0, 1'b0);
                end
                push_note(ln, 1'b0, 1'b1);
            end
            OP_HANGUP: begin
                if ((st == ST_CONNECTED || st == ST_RINGING || st == ST_RING_BACK) && linked) begin
                    // an unanswered caller's target drops back on-hook
                    line_state[pr]  = (st == ST_RING_BACK) ? ST_ON_HOOK : ST_DIAL_TONE;
                    line_linked[pr] = 1'b0;
                    line_peer[pr]   = '0;
                    push_note(pr, 1'b0, 1'b0);
                end
                line_linked[ln] = 1'b0;
                line_peer[ln]   = '0;
                line_state[ln]  = ST_ON_HOOK;
                push_note(ln, 1'b0, 1'b1);
            end
            OP_DIAL: begin
                if (st == ST_DIAL_TONE) begin
                    if (!known) begin
                        line_state[ln] = ST_ERROR;
                    end else if (tg == ln || line_linked[tg] || line_state[tg] != ST_ON_HOOK) begin
                        line_state[ln] = ST_BUSY;
                    end else begin
                        line_peer[ln]   = tg;
                        line_linked[ln] = 1'b1;
                        line_peer[tg]   = ln;
                        line_linked[tg] = 1'b1;
                        line_state[tg]  = ST_RINGING;
                        line_state[ln]  = ST_RING_BACK;
                        push_note(tg, 1'b0, 1'b0);
                    end
                end
                push_note(ln, 1'b0, 1'b1);
            end
            default: begin
                push_note(ln, st != ST_CONNECTED, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // transfer monitor: predicts on command transfers, checks notifications
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_note got;
        t_note want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                apply_command(t_opcode'(i_s_tuser), i_s_tdata[3:0], i_s_tdata[7:4],
                              i_s_tdata[8]);
                // typed rows replace the predicted notification for the line itself
                if (drv_typed_vld)
                    pending_notes[pending_notes.size()-1] = drv_typed;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.line   = o_m_tdata[3:0];
                got.state  = t_call_state'(o_m_tdata[6:4]);
                got.peer   = o_m_tdata[10:7];
                got.status = o_m_tuser;
                got.last   = o_m_tlast;
                if (pending_notes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected notification line %0d state %0d peer %0d",
                                 $time, got.line, got.state, got.peer);
                end else begin
                    want = pending_notes.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: notification mismatch:", $time,
                                     " expected line %0d state %0d peer %0d",
                                     want.line, want.state, want.peer,
                                     " status %0d last %0d,", want.status, want.last,
                                     " actual line %0d state %0d peer %0d",
                                     got.line, got.state, got.peer,
                                     " status %0d last %0d", got.status, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: changing stall patterns, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left  = 0;
        mode       = 0;
        mode_left  = 0;
        hold_ack   = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 1) == 0);
                    2:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one command and hold it until the transfer
    task automatic send_command(input t_opcode op, input logic [LINE_W-1:0] ln,
                                input logic [LINE_W-1:0] tg, input logic known,
                                input logic typed, input t_note tnote);
        i_s_tvalid    <= 1'b1;
        i_s_tdata     <= {7'd0, known, tg, ln};
        i_s_tuser     <= op;
        drv_typed_vld <= typed;
        drv_typed     <= tnote;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic add_row(input t_opcode op, input int ln, input int tg, input logic known,
                           input logic typed, input t_call_state st, input logic status);
        t_cmd_row r;
        r.op     = op;
        r.line   = LINE_W'(ln);
        r.target = LINE_W'(tg);
        r.known  = known;
        r.typed  = typed;
        r.state  = st;
        r.status = status;
        cmd_table.push_back(r);
    endtask

    // random line in a given state, starting the search at a random index
    function automatic int find_line(input t_call_state want);
        int base;
        base = $urandom_range(0, LINES - 1);
        for (int k = 0; k < LINES; k++)
            if (line_state[(base + k) % LINES] == want)
                return (base + k) % LINES;
        return -1;
    endfunction

    initial begin
        t_note             tnote;
        t_opcode           op;
        logic [LINE_W-1:0] ln;
        logic [LINE_W-1:0] tg;
        logic              known;
        int                roll;
        int                idx;
        int                burst_left;
        t_call_state       hang_pick [5];

        fail_count    = 0;
        hold_req      = 0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        drv_typed_vld = 1'b0;
        drv_typed     = '0;
        for (int k = 0; k < LINES; k++) begin
            line_state[k]  = ST_ON_HOOK;
            line_peer[k]   = '0;
            line_linked[k] = 1'b0;
        end
        hang_pick = '{ST_BUSY, ST_ERROR, ST_CONNECTED, ST_RING_BACK, ST_RINGING};

        // directed table: op, line, target, known, typed, line state, status
        add_row(OP_CHAT,   0,  0,  1'b0, 1'b1, ST_ON_HOOK,   1'b1); // chat refused after reset
        add_row(OP_HANGUP, 15, 0,  1'b0, 1'b1, ST_ON_HOOK,   1'b0); // hangup while idle
        add_row(OP_DIAL,   3,  15, 1'b1, 1'b1, ST_ON_HOOK,   1'b0); // dial without dial tone
        add_row(OP_PICKUP, 0,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   0,  5,  1'b0, 1'b1, ST_ERROR,     1'b0); // unknown extension
        add_row(OP_PICKUP, 0,  0,  1'b0, 1'b1, ST_ERROR,     1'b0); // pickup leaves error alone
        add_row(OP_HANGUP, 0,  0,  1'b0, 1'b1, ST_ON_HOOK,   1'b0);
        add_row(OP_PICKUP, 0,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   0,  0,  1'b1, 1'b1, ST_BUSY,      1'b0); // dialling itself
        add_row(OP_HANGUP, 0,  0,  1'b0, 1'b1, ST_ON_HOOK,   1'b0);
        add_row(OP_PICKUP, 0,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   0,  15, 1'b1, 1'b0, ST_ON_HOOK,   1'b0); // 15 rings, 0 rings back
        add_row(OP_PICKUP, 15, 0,  1'b0, 1'b0, ST_ON_HOOK,   1'b0); // answer: both connected
        add_row(OP_CHAT,   15, 0,  1'b0, 1'b0, ST_ON_HOOK,   1'b0); // chat accepted
        add_row(OP_PICKUP, 1,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   1,  15, 1'b1, 1'b1, ST_BUSY,      1'b0); // target already linked
        add_row(OP_HANGUP, 0,  0,  1'b0, 1'b0, ST_ON_HOOK,   1'b0); // 15 back to dial tone
        add_row(OP_HANGUP, 1,  0,  1'b0, 1'b1, ST_ON_HOOK,   1'b0);
        add_row(OP_PICKUP, 1,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   1,  15, 1'b1, 1'b1, ST_BUSY,      1'b0); // target off-hook, unlinked
        add_row(OP_HANGUP, 15, 0,  1'b0, 1'b1, ST_ON_HOOK,   1'b0);
        add_row(OP_HANGUP, 1,  0,  1'b0, 1'b1, ST_ON_HOOK,   1'b0);
        add_row(OP_PICKUP, 1,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   1,  15, 1'b1, 1'b0, ST_ON_HOOK,   1'b0);
        add_row(OP_HANGUP, 1,  0,  1'b0, 1'b0, ST_ON_HOOK,   1'b0); // caller gives up
        add_row(OP_PICKUP, 2,  0,  1'b0, 1'b1, ST_DIAL_TONE, 1'b0);
        add_row(OP_DIAL,   2,  7,  1'b1, 1'b0, ST_ON_HOOK,   1'b0);
        add_row(OP_HANGUP, 7,  0,  1'b0, 1'b0, ST_ON_HOOK,   1'b0); // callee rejects

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (cmd_table[i]) begin
            tnote.line   = cmd_table[i].line;
            tnote.state  = cmd_table[i].state;
            tnote.peer   = '0;
            tnote.status = cmd_table[i].status;
            tnote.last   = 1'b1;
            send_command(cmd_table[i].op, cmd_table[i].line, cmd_table[i].target,
                         cmd_table[i].known, cmd_table[i].typed, tnote);
        end

        // random call traffic, biased towards commands that move calls along
        tnote      = '0;
        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            roll  = $urandom_range(0, 99);
            op    = (roll < 30) ? OP_PICKUP : (roll < 50) ? OP_HANGUP :
                    (roll < 85) ? OP_DIAL : OP_CHAT;
            ln    = LINE_W'($urandom_range(0, LINES - 1));
            tg    = LINE_W'($urandom_range(0, LINES - 1));
            known = ($urandom_range(0, 7) != 0);
            idx   = -1;
            if (op == OP_PICKUP && $urandom_range(0, 1) == 0)
                idx = find_line(ST_RINGING);
            else if (op == OP_DIAL && $urandom_range(0, 3) != 0)
                idx = find_line(ST_DIAL_TONE);
            else if (op == OP_HANGUP && $urandom_range(0, 1) == 0)
                idx = find_line(hang_pick[$urandom_range(0, 4)]);
            if (idx >= 0)
                ln = LINE_W'(idx);
            send_command(op, ln, tg, known, 1'b0, tnote);

            // long output hold-off while commands keep coming
            if (n == 600)
                hold_req++;

            // one pause until every notification has drained
            if (n == 1300) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_notes.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    roll = $urandom_range(0, 6);
                    if (roll != 0) begin
                        i_s_tvalid <= 1'b0;
                        repeat (roll) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 40);
                end
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_notes.size() != 0) @(posedge i_clk);
        // room for any stray notification after the last expected one
        repeat (40) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_line_call_state_table_core: PASS");
        else
            $display("tb_line_call_state_table_core: FAIL");
        $finish;
    end

endmodule
